// ----- rtl/kflerp_pkg.sv -----
// ----------------------------------------------------------------------------
// kflerp_pkg
// Shared types and constants of the keyframe position interpolator.
// ----------------------------------------------------------------------------
package kflerp_pkg;

   localparam int POS_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int DIV_STEPS  = FRAC_W;
   localparam int STEP_W     = 4;
   localparam int NUM_COORDS = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int KCOUNT_W   = 5;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [2:0] CASE_DEFAULT = 3'd0;
   localparam logic [2:0] CASE_FIRST   = 3'd1;
   localparam logic [2:0] CASE_LAST    = 3'd2;
   localparam logic [2:0] CASE_INTERP  = 3'd3;
   localparam logic [2:0] CASE_WRITE   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_Y = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_Z = 2'd3;

   typedef struct packed {
      logic              opcode;
      logic [3:0]        key_slot;
      logic signed [31:0] key_tick;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
      logic signed [31:0] sample_tick;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [2:0]         case_taken;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] tick;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } key_type;

   typedef enum logic [1:0] {
      RD_ZERO     = 2'd0,
      RD_LAST     = 2'd1,
      RD_IDX      = 2'd2,
      RD_IDX_NEXT = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       req_load;
      logic       key_wr;
      rd_sel_type rd_sel;
      logic       prev_load;
      logic       idx_adv;
      logic       div_init;
      logic       div_step;
      logic       mul_go;
      logic [1:0] mul_coord;
      logic       res_load;
      logic [2:0] res_kind;
   } ctl_type;

   typedef struct packed {
      logic empty;
      logic s_le_tick;
      logic s_ge_tick;
   } sts_type;

endpackage

// ----- rtl/keyframe_position_lerp_top.sv -----
// ----------------------------------------------------------------------------
// keyframe_position_lerp_top
// Position keyframe track: key loads and linearly interpolated samples.
// ----------------------------------------------------------------------------
// rsp_valid is registered. Key writes and empty-track samples are answered
// straight from idle, samples before the first key or after the last key from
// ST_FIRST or ST_LAST, and interpolated samples after a key search, a 16-step
// divide and 3 multiplies. busy is high whenever the sequencer is out of idle,
// so a new request is taken only once the last one is through.
// Synchronous reset clears the control registers, valid flags and sequencer, not the key table.
module keyframe_position_lerp_top import kflerp_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_type ctl;
   sts_type sts;

   kflerp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .sts    (sts),
      .ctl    (ctl),
      .busy   (busy)
   );

   kflerp_datapath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

// ----- rtl/kflerp_ctrl.sv -----
// ----------------------------------------------------------------------------
// kflerp_ctrl
// Sequencer: key search, fraction divide, blend multiplies, result load.
// ----------------------------------------------------------------------------
module kflerp_ctrl import kflerp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    opcode,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FIRST = 8'b0000_0010,
      ST_LAST  = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_DRAIN = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ctl           = '0;
      ctl.rd_sel    = RD_ZERO;
      ctl.res_kind  = CASE_WRITE;
      ctl.mul_coord = cnt_ff[1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.req_load = 1'b1;
               if (opcode == OP_WRITE) begin
                  ctl.key_wr   = 1'b1;
                  ctl.res_load = 1'b1;
                  ctl.res_kind = CASE_WRITE;
               end else if (sts.empty) begin
                  ctl.res_load = 1'b1;
                  ctl.res_kind = CASE_DEFAULT;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (sts.s_le_tick) begin
               ctl.res_load = 1'b1;
               ctl.res_kind = CASE_FIRST;
               state_in     = ST_IDLE;
            end else begin
               ctl.prev_load = 1'b1;
               ctl.rd_sel    = RD_LAST;
               state_in      = ST_LAST;
            end
         end
         ST_LAST: begin
            if (sts.s_ge_tick) begin
               ctl.res_load = 1'b1;
               ctl.res_kind = CASE_LAST;
               state_in     = ST_IDLE;
            end else begin
               ctl.rd_sel = RD_IDX;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.s_ge_tick) begin
               ctl.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               ctl.prev_load = 1'b1;
               ctl.idx_adv   = 1'b1;
               ctl.rd_sel    = RD_IDX_NEXT;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_MUL: begin
            ctl.mul_go = 1'b1;
            if (cnt_ff == STEP_W'(NUM_COORDS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            ctl.res_load = 1'b1;
            ctl.res_kind = CASE_INTERP;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/kflerp_datapath.sv -----
// ----------------------------------------------------------------------------
// kflerp_datapath
// Key table, control registers, restoring fraction divider, shared blend
// multiplier and result register.
// ----------------------------------------------------------------------------
module kflerp_datapath import kflerp_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  ctl_type               ctl,
   output sts_type               sts,
   output rsp_type               rsp_data,
   output logic                  rsp_valid
);

   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   function automatic logic [POS_W-1:0] coord_of(key_type k, logic [1:0] c);
      logic [POS_W-1:0] v;
      case (c)
         2'd0:    v = k.x;
         2'd1:    v = k.y;
         default: v = k.z;
      endcase
      return v;
   endfunction

   logic [KCOUNT_W-1:0] key_count_ff;
   logic [POS_W-1:0]    default_x_ff, default_y_ff, default_z_ff;

   key_type             key_mem [MAX_KEYS];
   key_type             rd_key_ff, prev_ff, next_ff, key_in;
   logic [IDX_W-1:0]    rd_addr, wr_addr, idx_ff, last_idx;
   logic [CNT_W-1:0]    n_keys;
   logic                slot_ok;

   logic signed [31:0]  s_ff;
   logic [32:0]         num_c, den_c, den_ff;
   logic [33:0]         rem_ff, rem_sh, rem_sub;
   logic [FRAC_W-1:0]   quot_ff;
   logic                rem_ge;

   logic [POS_W-1:0]    next_coord, prev_coord;
   logic signed [32:0]  diff_c;
   logic signed [FRAC_W:0] frac_s;
   logic signed [49:0]  prod_c, prod_ff;
   logic [1:0]          coord_ff;
   logic                add_vld_ff;
   logic [POS_W-1:0]    sum_c;
   logic [NUM_COORDS-1:0][POS_W-1:0] pos_ff;

   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         default_x_ff <= '0;
         default_y_ff <= '0;
         default_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_COUNT: key_count_ff <= csr_wdata[KCOUNT_W-1:0];
            CSR_DEFAULT_X: default_x_ff <= csr_wdata;
            CSR_DEFAULT_Y: default_y_ff <= csr_wdata;
            CSR_DEFAULT_Z: default_z_ff <= csr_wdata;
            default:       key_count_ff <= key_count_ff;
         endcase
      end
   end

   assign n_keys   = (32'(key_count_ff) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                          : CNT_W'(key_count_ff);
   assign last_idx = IDX_W'(n_keys - CNT_W'(1));
   assign slot_ok  = 32'(req_data.key_slot) < 32'(MAX_KEYS);
   assign wr_addr  = IDX_W'(req_data.key_slot);

   assign key_in.tick = req_data.key_tick;
   assign key_in.x    = req_data.key_x;
   assign key_in.y    = req_data.key_y;
   assign key_in.z    = req_data.key_z;

   always_comb begin
      unique case (ctl.rd_sel)
         RD_ZERO:     rd_addr = '0;
         RD_LAST:     rd_addr = last_idx;
         RD_IDX:      rd_addr = idx_ff;
         RD_IDX_NEXT: rd_addr = idx_ff + IDX_W'(1);
         default:     rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.key_wr && slot_ok) begin
         key_mem[wr_addr] <= key_in;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         s_ff   <= req_data.sample_tick;
         idx_ff <= IDX_W'(1);
      end else if (ctl.idx_adv) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (ctl.prev_load) begin
         prev_ff <= rd_key_ff;
      end
   end

   assign sts.empty     = (n_keys == '0);
   assign sts.s_le_tick = (s_ff <= rd_key_ff.tick);
   assign sts.s_ge_tick = (s_ff >= rd_key_ff.tick);

   assign num_c   = {s_ff[31], s_ff} - {prev_ff.tick[31], prev_ff.tick};
   assign den_c   = {rd_key_ff.tick[31], rd_key_ff.tick} - {prev_ff.tick[31], prev_ff.tick};
   assign rem_sh  = {rem_ff[32:0], 1'b0};
   assign rem_ge  = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (ctl.div_init) begin
         next_ff <= rd_key_ff;
         rem_ff  <= {1'b0, num_c};
         den_ff  <= den_c;
         quot_ff <= '0;
      end else if (ctl.div_step) begin
         rem_ff  <= rem_ge ? rem_sub : rem_sh;
         quot_ff <= {quot_ff[FRAC_W-2:0], rem_ge};
      end
   end

   assign next_coord = coord_of(next_ff, ctl.mul_coord);
   assign prev_coord = coord_of(prev_ff, ctl.mul_coord);
   assign diff_c = $signed({next_coord[POS_W-1], next_coord}) -
                   $signed({prev_coord[POS_W-1], prev_coord});
   assign frac_s = $signed({1'b0, quot_ff});
   assign prod_c = diff_c * frac_s;
   assign sum_c  = coord_of(prev_ff, coord_ff) + prod_ff[FRAC_W+POS_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         add_vld_ff <= 1'b0;
      end else begin
         add_vld_ff <= ctl.mul_go;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_go) begin
         prod_ff  <= prod_c;
         coord_ff <= ctl.mul_coord;
      end
      if (add_vld_ff) begin
         pos_ff[coord_ff] <= sum_c;
      end
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.case_taken = ctl.res_kind;
      unique case (ctl.res_kind) inside
         CASE_DEFAULT: begin
            rsp_in.pos_x = default_x_ff;
            rsp_in.pos_y = default_y_ff;
            rsp_in.pos_z = default_z_ff;
         end
         CASE_FIRST, CASE_LAST: begin
            rsp_in.pos_x = rd_key_ff.x;
            rsp_in.pos_y = rd_key_ff.y;
            rsp_in.pos_z = rd_key_ff.z;
         end
         CASE_INTERP: begin
            rsp_in.pos_x = pos_ff[0];
            rsp_in.pos_y = pos_ff[1];
            rsp_in.pos_z = pos_ff[2];
         end
         default: begin
            rsp_in.pos_x = '0;
            rsp_in.pos_y = '0;
            rsp_in.pos_z = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.res_load;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.res_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- dv/keyframe_position_lerp_top_test.sv -----
// ----------------------------------------------------------------------------
// keyframe_position_lerp_top_test
// Drives key loads and track samples into the interpolator and compares every
// position it returns with a local fixed-point model of the key track.
// ----------------------------------------------------------------------------
import kflerp_pkg::*;

class position_track_sb;

   localparam int TRACK_DEPTH = 16;

   key_type            track [TRACK_DEPTH];
   logic [4:0]         key_count;
   logic signed [31:0] dflt_x, dflt_y, dflt_z;
   rsp_type            pending_pos [$];
   int                 errors;

   function new();
      key_count = '0;
      dflt_x    = '0;
      dflt_y    = '0;
      dflt_z    = '0;
      errors    = 0;
   endfunction

   function void set_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
         CSR_KEY_COUNT: key_count = data[4:0];
         CSR_DEFAULT_X: dflt_x = data;
         CSR_DEFAULT_Y: dflt_y = data;
         CSR_DEFAULT_Z: dflt_z = data;
         default: ;
      endcase
   endfunction

   // a + floor((b - a) * frac / 2^16)
   function logic signed [31:0] blend(input longint a, input longint b, input longint frac);
      longint prod;
      prod = (b - a) * frac;
      return 32'(a + (prod >>> FRAC_W));
   endfunction

   function void log_request(input req_type r);
      rsp_type e;
      int      n;
      int      nx;
      longint  s;
      longint  t_prev;
      longint  frac;
      e = '0;
      if (r.opcode == OP_WRITE) begin
         track[r.key_slot] = '{r.key_tick, r.key_x, r.key_y, r.key_z};
         e.case_taken = CASE_WRITE;
      end else begin
         n = (key_count > TRACK_DEPTH) ? TRACK_DEPTH : int'(key_count);
         s = r.sample_tick;
         if (n == 0) begin
            e.pos_x = dflt_x;
            e.pos_y = dflt_y;
            e.pos_z = dflt_z;
            e.case_taken = CASE_DEFAULT;
         end else if (s <= track[0].tick) begin
            e.pos_x = track[0].x;
            e.pos_y = track[0].y;
            e.pos_z = track[0].z;
            e.case_taken = CASE_FIRST;
         end else if (s >= track[n-1].tick) begin
            e.pos_x = track[n-1].x;
            e.pos_y = track[n-1].y;
            e.pos_z = track[n-1].z;
            e.case_taken = CASE_LAST;
         end else begin
            nx = n - 1;
            for (int i = n - 2; i >= 1; i--) begin
               if (track[i].tick > s) nx = i;
            end
            t_prev = track[nx-1].tick;
            frac = ((s - t_prev) <<< FRAC_W) / (longint'(track[nx].tick) - t_prev);
            e.pos_x = blend(track[nx-1].x, track[nx].x, frac);
            e.pos_y = blend(track[nx-1].y, track[nx].y, frac);
            e.pos_z = blend(track[nx-1].z, track[nx].z, frac);
            e.case_taken = CASE_INTERP;
         end
      end
      pending_pos.insert(pending_pos.size(), e);
   endfunction

   function void check_position(input rsp_type a);
      rsp_type e;
      if (pending_pos.size() == 0) begin
         $error("result with no transfer pending: case_taken %0d", a.case_taken);
         errors++;
         return;
      end
      e = pending_pos.pop_front();
      if (a.pos_x !== e.pos_x) begin
         $error("pos_x expected %0d actual %0d", e.pos_x, a.pos_x);
         errors++;
      end
      if (a.pos_y !== e.pos_y) begin
         $error("pos_y expected %0d actual %0d", e.pos_y, a.pos_y);
         errors++;
      end
      if (a.pos_z !== e.pos_z) begin
         $error("pos_z expected %0d actual %0d", e.pos_z, a.pos_z);
         errors++;
      end
      if (a.case_taken !== e.case_taken) begin
         $error("case_taken expected %0d actual %0d", e.case_taken, a.case_taken);
         errors++;
      end
   endfunction

endclass

module keyframe_position_lerp_top_test;

   localparam int TRACK_DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 850;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int               cycle_count = 0;
   bit               idling = 1'b1;
   position_track_sb sb = new();

   keyframe_position_lerp_top #(
      .MAX_KEYS(TRACK_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_position(rsp_data);
   end

   function automatic req_type noise_req();
      req_type r;
      r.opcode      = 1'($urandom);
      r.key_slot    = 4'($urandom);
      r.key_tick    = $urandom;
      r.key_x       = $urandom;
      r.key_y       = $urandom;
      r.key_z       = $urandom;
      r.sample_tick = $urandom;
      return r;
   endfunction

   // hold start and data until the transfer; sometimes drop start for a random gap first
   task automatic send_item(input req_type r);
      if (idling && $urandom_range(0, 99) < 28) begin
         start <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 1) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sb.log_request(r);
   endtask

   task automatic send_probe(input logic [31:0] tick);
      req_type r;
      r = noise_req();
      r.opcode      = OP_SAMPLE;
      r.sample_tick = tick;
      send_item(r);
   endtask

   task automatic send_key(input int slot, input logic [31:0] tick,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      req_type r;
      r = noise_req();
      r.opcode   = OP_WRITE;
      r.key_slot = 4'(slot);
      r.key_tick = tick;
      r.key_x    = x;
      r.key_y    = y;
      r.key_z    = z;
      send_item(r);
   endtask

   // write all registers once the block has drained
   task automatic configure(input logic [31:0] kc, input logic [31:0] dx,
                            input logic [31:0] dy, input logic [31:0] dz);
      logic [31:0]          vals [4];
      logic [CSR_IDX_W-1:0] idx [4];
      vals = '{kc, dx, dy, dz};
      idx  = '{CSR_KEY_COUNT, CSR_DEFAULT_X, CSR_DEFAULT_Y, CSR_DEFAULT_Z};
      start <= 1'b0;
      while (sb.pending_pos.size() != 0 || busy) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_register(idx[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   // rewrite every slot with ascending ticks, narrow or spread over the full range
   task automatic load_track(input bit wide);
      longint t;
      t = longint'($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < TRACK_DEPTH; i++) begin
         if (wide) begin
            t = -64'sd2147483648 + longint'(i) * 64'sd268435456
                + longint'($urandom_range(0, 268435455));
         end else begin
            t += longint'($urandom_range(1, 300));
         end
         send_key(i, 32'(t), $urandom, $urandom, $urandom);
      end
   endtask

   function automatic logic [31:0] pick_probe(input int n);
      longint lo;
      longint hi;
      int     i;
      if (n == 0) return $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            if (n < 2) return sb.track[0].tick;
            i  = $urandom_range(0, n - 2);
            lo = sb.track[i].tick;
            hi = sb.track[i+1].tick;
            if (hi <= lo) return 32'(lo);
            return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
         end
         6: return sb.track[$urandom_range(0, n - 1)].tick;
         7: return 32'(longint'(sb.track[0].tick) - longint'($urandom_range(0, 1)));
         8: return 32'(longint'(sb.track[n-1].tick) + longint'($urandom_range(0, 1)));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      req_type     r;
      int          made;
      int          n;
      logic [4:0]  kc;
      logic [31:0] x_end;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty track returns the defaults
      configure(32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_8000);
      send_probe(32'h8000_0000);
      send_probe(32'h7fff_ffff);

      // full table: extreme end ticks, alternating extreme x
      for (int i = 0; i < TRACK_DEPTH; i++) begin
         x_end = i[0] ? 32'h7fff_ffff : 32'h8000_0000;
         if (i == 0) send_key(i, 32'h8000_0000, x_end, 32'(i - 5) << 16, $urandom);
         else if (i == TRACK_DEPTH - 1)
            send_key(i, 32'h7fff_ffff, x_end, 32'(i - 5) << 16, $urandom);
         else send_key(i, 32'(i * 100 - 700), x_end, 32'(i - 5) << 16, $urandom);
      end
      configure(32'd16, $urandom, $urandom, $urandom);
      send_probe(32'h8000_0000);
      send_probe(32'h7fff_ffff);
      send_probe(32'd0);
      send_probe(-32'sd600);
      send_probe(-32'sd1);
      send_probe(32'h7fff_fffe);

      // key count past the table depth
      configure(32'd31, $urandom, $urandom, $urandom);
      send_probe(32'd100);

      made = 0;
      for (int p = 0; made < RANDOM_ITEMS; p++) begin
         idling = (p != 3);
         case (p)
            0: kc = 5'd16;
            1: kc = 5'd0;
            2: kc = 5'd1;
            3: kc = 5'd31;
            default: begin
               case ($urandom_range(0, 4))
                  0: kc = 5'($urandom_range(17, 31));
                  1: kc = 5'd2;
                  default: kc = 5'($urandom_range(0, 16));
               endcase
            end
         endcase
         configure({27'($urandom), kc}, $urandom, $urandom, $urandom);
         if (p < 2 || $urandom_range(0, 1) == 0) begin
            load_track(p[0] ^ 1'($urandom_range(0, 1)));
            made += TRACK_DEPTH;
         end
         n = (kc > TRACK_DEPTH) ? TRACK_DEPTH : int'(kc);
         repeat (100) begin
            if ($urandom_range(0, 99) < 15) begin
               r = noise_req();
               r.opcode = OP_WRITE;
               send_item(r);
            end else begin
               send_probe(pick_probe(n));
            end
            made++;
         end
      end
      start <= 1'b0;

      while (sb.pending_pos.size() != 0) @(posedge clock);
      repeat (2 * TRACK_DEPTH + 30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/kflerp_pkg.sv
rtl/kflerp_ctrl.sv
rtl/kflerp_datapath.sv
rtl/keyframe_position_lerp_top.sv
dv/keyframe_position_lerp_top_test.sv
